>>> hw/rtl/lpr_pkg.sv
// Shared constants, types and state codes of the linear PCM resampler.
package lpr_pkg;

  localparam int unsigned PHASE_FRAC_BITS = 16;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned STEP_W          = 18;
  localparam int unsigned COUNT_W         = 16;
  localparam int unsigned POS_W           = PHASE_FRAC_BITS + 3;
  localparam int unsigned WIDE_W          = (STEP_W > POS_W) ? STEP_W : POS_W;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = STEP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = CFG_IDX_W'(1);

  localparam logic [POS_W-1:0] PH_ONE   = POS_W'(1) << PHASE_FRAC_BITS;
  localparam logic [POS_W-1:0] STEP_MIN = PH_ONE >> 3;
  localparam logic [POS_W-1:0] STEP_MAX = PH_ONE << 1;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(PH_ONE);

  typedef struct packed {
    logic             bypass;
    logic [POS_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] s0;
    logic signed [SAMPLE_W-1:0] s1;
    logic [PHASE_FRAC_BITS-1:0] frac;
  } blend_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYPASS,
    ST_CHECK,
    ST_PUSH,
    ST_EMIT,
    ST_FINISH
  } seq_state_e;

endpackage

>>> hw/rtl/lpr_if.sv
// Valid/ready stream interfaces for source samples and resampled results.
interface lpr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lpr_pkg::SAMPLE_W-1:0] sample_in;
  logic                                chunk_end;

  modport source (output valid, output sample_in, output chunk_end, input ready);
  modport sink   (input valid, input sample_in, input chunk_end, output ready);
endinterface

interface lpr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lpr_pkg::SAMPLE_W-1:0] sample_out;
  logic                                run_last;

  modport source (output valid, output sample_out, output run_last, input ready);
  modport sink   (input valid, input sample_out, input run_last, output ready);
endinterface

>>> hw/rtl/lpr_cfg_regs.sv
// Configuration registers and clamping of the phase step.
module lpr_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [lpr_pkg::CFG_IDX_W-1:0]    idx_i,
  input  logic [lpr_pkg::CFG_DATA_W-1:0]   data_i,
  output lpr_pkg::cfg_t                    cfg_o
);

  logic                           bypass_q, bypass_d;
  logic [lpr_pkg::STEP_W-1:0]     step_q, step_d;
  logic [lpr_pkg::WIDE_W-1:0]     step_wide;

  always_comb begin
    bypass_d = bypass_q;
    step_d   = step_q;
    if (we_i) begin
      unique case (idx_i)
        lpr_pkg::CFG_BYPASS:     bypass_d = data_i[0];
        lpr_pkg::CFG_PHASE_STEP: step_d   = data_i[lpr_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
      step_q   <= lpr_pkg::STEP_RESET;
    end else begin
      bypass_q <= bypass_d;
      step_q   <= step_d;
    end
  end

  always_comb begin
    step_wide = lpr_pkg::WIDE_W'(step_q);
    if (step_wide < lpr_pkg::WIDE_W'(lpr_pkg::STEP_MIN)) begin
      step_wide = lpr_pkg::WIDE_W'(lpr_pkg::STEP_MIN);
    end
    if (step_wide > lpr_pkg::WIDE_W'(lpr_pkg::STEP_MAX)) begin
      step_wide = lpr_pkg::WIDE_W'(lpr_pkg::STEP_MAX);
    end
    cfg_o.bypass = bypass_q;
    cfg_o.step   = step_wide[lpr_pkg::POS_W-1:0];
  end

endmodule

>>> hw/rtl/lpr_blend_unit.sv
// Shared blend unit: registered multiply, then add and truncation toward zero.
module lpr_blend_unit (
  input  logic                                clk_i,
  input  lpr_pkg::blend_req_t                 req_i,
  output logic signed [lpr_pkg::SAMPLE_W-1:0] value_o
);

  localparam int unsigned FRAC   = lpr_pkg::PHASE_FRAC_BITS;
  localparam int unsigned SW     = lpr_pkg::SAMPLE_W;
  localparam int unsigned PROD_W = SW + FRAC + 2;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned QUO_W  = SUM_W - FRAC;

  logic signed [SW:0]         diff;
  logic signed [FRAC:0]       frac_s;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [SW-1:0]       s0_q;
  logic signed [SUM_W-1:0]    sum;
  logic [QUO_W-1:0]           quo;

  always_comb begin
    diff   = $signed({req_i.s1[SW-1], req_i.s1}) - $signed({req_i.s0[SW-1], req_i.s0});
    frac_s = $signed({1'b0, req_i.frac});
    prod_d = diff * frac_s;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= prod_d;
      s0_q   <= req_i.s0;
    end
  end

  always_comb begin
    sum = $signed({{(SUM_W - SW - FRAC){s0_q[SW-1]}}, s0_q, {FRAC{1'b0}}})
        + $signed({prod_q[PROD_W-1], prod_q});
    quo = sum[SUM_W-1:FRAC];
    if (sum[SUM_W-1] && (sum[FRAC-1:0] != '0)) begin
      quo = quo + QUO_W'(1);
    end
    value_o = quo[SW-1:0];
  end

endmodule

>>> hw/rtl/lpr_seq.sv
// Sequencer: walks output positions, drives the blend unit, holds the result register.
module lpr_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lpr_in_if.sink                              in_i,
  lpr_out_if.source                           out_o,
  input  lpr_pkg::cfg_t                       cfg_i,
  output lpr_pkg::blend_req_t                 blend_req_o,
  input  logic signed [lpr_pkg::SAMPLE_W-1:0] blend_value_i
);

  localparam int unsigned SW = lpr_pkg::SAMPLE_W;
  localparam int unsigned PW = lpr_pkg::POS_W;

  lpr_pkg::seq_state_e state_q, state_d;

  logic signed [SW-1:0]            x_q, x_d;
  logic                            last_q, last_d;
  logic [PW-1:0]                   pos_q, pos_d;
  logic signed [SW-1:0]            s0_q, s0_d;
  logic signed [SW-1:0]            pend_q, pend_d;
  logic                            pend_valid_q, pend_valid_d;
  logic                            more_q, more_d;
  logic                            out_valid_q, out_valid_d;
  logic signed [SW-1:0]            out_sample_q, out_sample_d;
  logic                            out_last_q, out_last_d;
  logic signed [SW-1:0]            prev_q, prev_d;
  logic                            have_prev_q, have_prev_d;
  logic [PW-1:0]                   phase_q, phase_d;
  logic [lpr_pkg::COUNT_W-1:0]     count_q, count_d;

  logic                            out_free;
  logic                            out_load;
  logic [PW:0]                     pos_ahead;
  logic                            emits;
  logic                            blend_start;

  assign out_free  = !out_valid_q || out_o.ready;
  assign pos_ahead = {1'b0, pos_q} + {1'b0, cfg_i.step};
  assign emits     = last_q ? (pos_ahead <= {1'b0, lpr_pkg::STEP_MAX})
                            : (pos_q < lpr_pkg::PH_ONE);

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    last_d       = last_q;
    pos_d        = pos_q;
    s0_d         = s0_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    more_d       = more_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    phase_d      = phase_q;
    count_d      = count_q;
    out_load     = 1'b0;
    blend_start  = 1'b0;
    in_i.ready   = 1'b0;

    unique case (state_q)
      lpr_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          x_d          = in_i.sample_in;
          last_d       = in_i.chunk_end;
          pend_valid_d = 1'b0;
          pos_d        = have_prev_q ? phase_q : lpr_pkg::PH_ONE;
          s0_d         = have_prev_q ? prev_q : in_i.sample_in;
          state_d      = cfg_i.bypass ? lpr_pkg::ST_BYPASS : lpr_pkg::ST_CHECK;
        end
      end
      lpr_pkg::ST_BYPASS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_sample_d = x_q;
          out_last_d   = 1'b1;
          state_d      = lpr_pkg::ST_IDLE;
        end
      end
      lpr_pkg::ST_CHECK: begin
        more_d = emits;
        if (pend_valid_q) begin
          state_d = lpr_pkg::ST_PUSH;
        end else if (emits) begin
          blend_start = 1'b1;
          state_d     = lpr_pkg::ST_EMIT;
        end else begin
          state_d = lpr_pkg::ST_FINISH;
        end
      end
      lpr_pkg::ST_PUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_sample_d = pend_q;
          out_last_d   = !more_q;
          pend_valid_d = 1'b0;
          if (more_q) begin
            blend_start = 1'b1;
            state_d     = lpr_pkg::ST_EMIT;
          end else begin
            state_d = lpr_pkg::ST_FINISH;
          end
        end
      end
      lpr_pkg::ST_EMIT: begin
        pend_d       = (pos_q >= lpr_pkg::PH_ONE) ? x_q : blend_value_i;
        pend_valid_d = 1'b1;
        pos_d        = pos_ahead[PW-1:0];
        state_d      = lpr_pkg::ST_CHECK;
      end
      lpr_pkg::ST_FINISH: begin
        if (last_q) begin
          prev_d      = '0;
          phase_d     = '0;
          have_prev_d = 1'b0;
          count_d     = '0;
        end else begin
          prev_d      = x_q;
          phase_d     = pos_q - lpr_pkg::PH_ONE;
          have_prev_d = 1'b1;
          count_d     = count_q + lpr_pkg::COUNT_W'(1);
        end
        state_d = lpr_pkg::ST_IDLE;
      end
      default: state_d = lpr_pkg::ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lpr_pkg::ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_q       <= '0;
      have_prev_q  <= 1'b0;
      phase_q      <= '0;
      count_q      <= '0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      prev_q       <= prev_d;
      have_prev_q  <= have_prev_d;
      phase_q      <= phase_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    last_q       <= last_d;
    pos_q        <= pos_d;
    s0_q         <= s0_d;
    pend_q       <= pend_d;
    more_q       <= more_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  assign blend_req_o.start = blend_start;
  assign blend_req_o.s0    = s0_q;
  assign blend_req_o.s1    = x_q;
  assign blend_req_o.frac  = pos_q[lpr_pkg::PHASE_FRAC_BITS-1:0];

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.run_last   = out_last_q;

endmodule

>>> hw/rtl/linear_pcm_resampler.sv
// Top level of the linear PCM resampler.
//
//   channel  direction  payload                    handshake
//   in_i     sink       sample_in[15:0], chunk_end  valid/ready
//   out_o    source     sample_out[15:0], run_last  valid/ready
//   cfg      write      cfg_idx_i[1:0], cfg_data_i  cfg_we_i, no wait
//
// Bypass: one result per input. Resampling: k results per input (up to 16),
// the sequencer stepping one position at a time through the shared
// multiplier. Not ready while an input is in progress. A stalled output
// holds the sequencer before its next result.
// Reset clears the chunk state and loads bypass on with a step of one.
module linear_pcm_resampler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lpr_in_if.sink                          in_i,
  lpr_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [lpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lpr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  lpr_pkg::cfg_t                       cfg;
  lpr_pkg::blend_req_t                 blend_req;
  logic signed [lpr_pkg::SAMPLE_W-1:0] blend_value;

  lpr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  lpr_blend_unit u_blend (
    .clk_i   (clk_i),
    .req_i   (blend_req),
    .value_o (blend_value)
  );

  lpr_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .cfg_i         (cfg),
    .blend_req_o   (blend_req),
    .blend_value_i (blend_value)
  );

endmodule

>>> hw/rtl/lpr_checker.sv
// Port-level assertions for the linear PCM resampler, bound to the top level.
module lpr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [lpr_pkg::SAMPLE_W-1:0]    out_sample_i,
  input logic                            out_last_i,
  input logic                            cfg_we_i,
  input logic [lpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [lpr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic bypass_q, bypass_d;

  always_comb begin
    bypass_d = bypass_q;
    if (cfg_we_i && (cfg_idx_i == lpr_pkg::CFG_BYPASS)) begin
      bypass_d = cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
    end else begin
      bypass_q <= bypass_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i) && $stable(out_last_i))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready again straight after a transaction");

  a_bypass_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bypass_q && out_valid_i |-> out_last_i)
    else $error("bypass result without run_last");

endmodule

bind linear_pcm_resampler lpr_checker u_lpr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out),
  .out_last_i   (out_o.run_last),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i)
);
